// File: hdl/bpl_pkg.sv
// ----------------------------------------------------------------------------
// bpl_pkg
// Shared types and constants for the bounded positional list: operation and
// status codes, field widths and the command broadcast to the cell row.
// ----------------------------------------------------------------------------
package bpl_pkg;

    // fixed field widths
    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 7;
    localparam int STAT_W   = 2;
    localparam int LEN_OUT_W = 7;

    // operation codes of a request
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_TAIL = 3'd0,
        OP_POP_TAIL  = 3'd1,
        OP_PUSH_HEAD = 3'd2,
        OP_POP_HEAD  = 3'd3,
        OP_INSERT_AT = 3'd4,
        OP_DELETE_AT = 3'd5
    } t_op;

    // result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // command broadcast to every cell of the row
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] idx;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: hdl/bounded_positional_list.sv
// ----------------------------------------------------------------------------
// bounded_positional_list
// Ordered list of up to DEPTH signed 32-bit values with push/pop at either
// end and insert/delete at a 1-based position.
// ----------------------------------------------------------------------------
// The list is a row of DEPTH cells, entry 0 at the head. The whole row shifts
// at once for an insert or delete at any position, so one request is accepted
// per cycle while o_stall is low, and its result appears in the output register
// on the next cycle. o_stall rises only while a result is held in the output
// register and the downstream side stalls it. Position 0 is taken as 1, a
// position past the length goes to the tail, a delete from an empty list
// reports empty and an insert into a full list is dropped and reported full.
// Unused operation codes leave the list unchanged.
module bounded_positional_list
    import bpl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [OP_W-1:0]      i_operation,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0]     i_position,
    // result channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [STAT_W-1:0]    o_status,
    output logic signed [VAL_W-1:0] o_removed_value,
    output logic [LEN_OUT_W-1:0] o_length_after
);

    localparam int LEN_W = $clog2(DEPTH + 1);

    logic                 accept;
    logic [LEN_W-1:0]     r_length;
    logic [LEN_W-1:0]     n_length;
    logic [POS_W-1:0]     len_ext;
    logic [POS_W-1:0]     last_ext;
    logic [POS_W-1:0]     pos_idx;
    logic                 full;
    logic                 empty;
    logic                 is_ins;
    logic                 is_del;
    logic [POS_W-1:0]     idx;
    t_status              status;
    t_cell_cmd            cmd;

    logic                 r_out_valid;
    logic [STAT_W-1:0]    r_status;
    logic [VAL_W-1:0]     r_removed;
    logic [LEN_OUT_W-1:0] r_len_out;
    logic [VAL_W-1:0]     removed;

    logic [VAL_W-1:0]     cell_val  [DEPTH];
    logic [VAL_W-1:0]     cell_pick [DEPTH];

    // handshake
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    // length and position arithmetic
    assign full     = (r_length == LEN_W'(DEPTH));
    assign empty    = (r_length == '0);
    assign len_ext  = POS_W'(r_length);
    assign last_ext = empty ? '0 : len_ext - POS_W'(1);
    assign pos_idx  = (i_position == '0) ? '0 : i_position - POS_W'(1);

    // decode the request
    always_comb begin
        is_ins = 1'b0;
        is_del = 1'b0;
        idx    = '0;
        unique case (t_op'(i_operation))
            OP_PUSH_TAIL: begin
                is_ins = 1'b1;
                idx    = len_ext;
            end
            OP_POP_TAIL: begin
                is_del = 1'b1;
                idx    = last_ext;
            end
            OP_PUSH_HEAD: begin
                is_ins = 1'b1;
            end
            OP_POP_HEAD: begin
                is_del = 1'b1;
            end
            OP_INSERT_AT: begin
                is_ins = 1'b1;
                idx    = (pos_idx > len_ext) ? len_ext : pos_idx;
            end
            OP_DELETE_AT: begin
                is_del = 1'b1;
                idx    = (pos_idx > last_ext) ? last_ext : pos_idx;
            end
            default: begin
            end
        endcase
    end

    // status and new length
    always_comb begin
        status   = ST_DONE;
        n_length = r_length;
        if (is_ins) begin
            if (full) begin
                status = ST_FULL;
            end else begin
                n_length = r_length + LEN_W'(1);
            end
        end else if (is_del) begin
            if (empty) begin
                status = ST_EMPTY;
            end else begin
                n_length = r_length - LEN_W'(1);
            end
        end
    end

    // command to the cell row
    assign cmd.ins   = accept && is_ins && !full;
    assign cmd.del   = accept && is_del && !empty;
    assign cmd.idx   = idx;
    assign cmd.value = i_value;

    // row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [VAL_W-1:0] left;
        logic [VAL_W-1:0] right;
        if (g == 0) begin : g_head
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_val[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_val[g+1];
        end
        bpl_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_left  (left),
            .i_right (right),
            .o_value (cell_val[g]),
            .o_pick  (cell_pick[g])
        );
    end

    // or together the picked cell values
    always_comb begin
        removed = '0;
        for (int k = 0; k < DEPTH; k++) begin
            removed = removed | cell_pick[k];
        end
    end

    // length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length <= '0;
        end else if (accept) begin
            r_length <= n_length;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status  <= status;
            r_removed <= removed;
            r_len_out <= LEN_OUT_W'(n_length);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_removed;
    assign o_length_after  = r_len_out;

endmodule

// File: hdl/bpl_cell.sv
// ----------------------------------------------------------------------------
// bpl_cell
// One storage cell of the list row. On an insert it takes the new value or
// its left neighbor's value; on a delete it takes its right neighbor's value.
// ----------------------------------------------------------------------------
module bpl_cell
    import bpl_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_cmd        i_cmd,
    input  logic [VAL_W-1:0] i_left,
    input  logic [VAL_W-1:0] i_right,
    output logic [VAL_W-1:0] o_value,
    output logic [VAL_W-1:0] o_pick
);

    localparam logic [POS_W-1:0] C_IDX = POS_W'(CELL_IDX);

    logic [VAL_W-1:0] r_value;
    logic [VAL_W-1:0] n_value;
    logic             at_idx;
    logic             above_idx;

    assign at_idx    = (C_IDX == i_cmd.idx);
    assign above_idx = (C_IDX > i_cmd.idx);

    // next value: shift right on insert, shift left on delete
    always_comb begin
        n_value = r_value;
        if (i_cmd.ins) begin
            if (above_idx) begin
                n_value = i_left;
            end else if (at_idx) begin
                n_value = i_cmd.value;
            end
        end else if (i_cmd.del) begin
            if (above_idx || at_idx) begin
                n_value = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    // value leaving the list, gated onto the shared or-bus
    assign o_pick  = (i_cmd.del && at_idx) ? r_value : '0;
    assign o_value = r_value;

endmodule

// File: hdl/bpl_checker.sv
// ----------------------------------------------------------------------------
// bpl_checker
// Port-level checks for the bounded positional list, bound to the top level.
// ----------------------------------------------------------------------------
module bpl_checker
    import bpl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_stall,
    input logic                 o_valid,
    input logic                 i_stall,
    input logic [STAT_W-1:0]    o_status,
    input logic [VAL_W-1:0]     o_removed_value,
    input logic [LEN_OUT_W-1:0] o_length_after
);

    // a held result does not change
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status)
            && $stable(o_removed_value) && $stable(o_length_after))
        else $error("result changed while stalled");

    // the request side stalls only behind a held result
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without a held result");

    // an empty report leaves an empty list and no removed value
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_length_after == '0
            && o_removed_value == '0)
        else $error("empty report with entries or a value");

    // a full report means the list holds DEPTH entries
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_length_after == LEN_OUT_W'(DEPTH)
            && o_removed_value == '0)
        else $error("full report with wrong length");

    // consecutive results change the length by at most one
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall) ##1 o_valid |->
            o_length_after == $past(o_length_after)
            || o_length_after == $past(o_length_after) + LEN_OUT_W'(1)
            || o_length_after + LEN_OUT_W'(1) == $past(o_length_after))
        else $error("length moved by more than one");

endmodule

bind bounded_positional_list bpl_checker #(
    .DEPTH (DEPTH)
) u_bpl_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_length_after  (o_length_after)
);

// File: bench/list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// list_checker
// Watches the request and result channels of the bounded positional list,
// keeps its own copy of the list, and compares every result with the oldest
// outstanding prediction. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
module list_checker
    import bpl_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // request channel
    input  logic                    i_req_valid,
    input  logic                    i_req_stall,
    input  logic [OP_W-1:0]         i_operation,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0]        i_position,
    // result channel
    input  logic                    i_res_valid,
    input  logic                    i_res_stall,
    input  logic [STAT_W-1:0]       i_status,
    input  logic signed [VAL_W-1:0] i_removed_value,
    input  logic [LEN_OUT_W-1:0]    i_length_after,
    // counts for the top
    output int                      o_fail_count,
    output int                      o_pending,
    output int                      o_checked,
    output int                      o_empty_hits,
    output int                      o_full_hits
);

    typedef struct {
        logic [STAT_W-1:0]       status;
        logic signed [VAL_W-1:0] removed;
        logic [LEN_OUT_W-1:0]    length;
    } t_list_result;

    // shadow copy of the list, head at index 0
    logic signed [VAL_W-1:0] shadow_list[$];
    // predicted results waiting for the block
    t_list_result            outstanding_results[$];

    int fails      = 0;
    int checked    = 0;
    int empty_hits = 0;
    int full_hits  = 0;

    // one line per mismatch, then count it
    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // apply one request to the shadow list and return the result it gives
    function automatic t_list_result predict_list_op(input logic [OP_W-1:0] op,
                                                     input logic signed [VAL_W-1:0] val,
                                                     input logic [POS_W-1:0] pos);
        t_list_result r;
        int n;
        int idx;
        n = shadow_list.size();
        r.status  = ST_DONE;
        r.removed = '0;
        // position zero counts as the first entry
        idx = (pos == '0) ? 0 : int'(pos) - 1;
        case (op)
            OP_PUSH_TAIL, OP_PUSH_HEAD, OP_INSERT_AT: begin
                if (n >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    if (op == OP_PUSH_TAIL) idx = n;
                    else if (op == OP_PUSH_HEAD) idx = 0;
                    else if (idx > n) idx = n;
                    shadow_list.insert(idx, val);
                end
            end
            OP_POP_TAIL, OP_POP_HEAD, OP_DELETE_AT: begin
                if (n == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    if (op == OP_POP_TAIL) idx = n - 1;
                    else if (op == OP_POP_HEAD) idx = 0;
                    else if (idx > n - 1) idx = n - 1;
                    r.removed = shadow_list[idx];
                    shadow_list.delete(idx);
                end
            end
            default: ;
        endcase
        r.length = LEN_OUT_W'(shadow_list.size());
        return r;
    endfunction

    // results first: a result never belongs to a request taken at the same edge
    always @(posedge i_clk) begin
        t_list_result want;
        if (!i_rst_n) begin
            shadow_list.delete();
            outstanding_results.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (outstanding_results.size() == 0) begin
                    report_mismatch("result with no request outstanding", 1, 0);
                end else begin
                    want = outstanding_results.pop_front();
                    checked++;
                    if (i_status !== want.status)
                        report_mismatch("status", i_status, want.status);
                    if (i_removed_value !== want.removed)
                        report_mismatch("removed_value", i_removed_value, want.removed);
                    if (i_length_after !== want.length)
                        report_mismatch("length_after", i_length_after, want.length);
                    if (want.status == ST_EMPTY) empty_hits++;
                    if (want.status == ST_FULL) full_hits++;
                end
            end
            if (i_req_valid && !i_req_stall)
                outstanding_results.push_back(
                    predict_list_op(i_operation, i_value, i_position));
        end
        o_fail_count <= fails;
        o_pending    <= outstanding_results.size();
        o_checked    <= checked;
        o_empty_hits <= empty_hits;
        o_full_hits  <= full_hits;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the bounded positional list. A directed pass hits
// the empty, full, clamped-position and unused-code cases, then biased random
// requests walk the list between empty and full under four idle/stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
    import bpl_pkg::*;

    localparam int DEPTH = 16;
    localparam int PHASE_REQUESTS = 468;
    localparam int MODE_RUN = 30;

    // codes the block leaves unused
    localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

    // random walk bias
    typedef enum int {
        WALK_FILL,
        WALK_DRAIN,
        WALK_MIXED
    } t_walk;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    req_valid;
    logic                    req_stall;
    logic [OP_W-1:0]         req_operation;
    logic signed [VAL_W-1:0] req_value;
    logic [POS_W-1:0]        req_position;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    logic [STAT_W-1:0]       res_status;
    logic signed [VAL_W-1:0] res_removed_value;
    logic [LEN_OUT_W-1:0]    res_length_after;

    int fail_count;
    int pending;
    int checked;
    int empty_hits;
    int full_hits;
    int idle_pct;
    int stall_pct = 0;
    int request_count;

    bounded_positional_list #(
        .DEPTH(DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (req_valid),
        .o_stall         (req_stall),
        .i_operation     (req_operation),
        .i_value         (req_value),
        .i_position      (req_position),
        .o_valid         (res_valid),
        .i_stall         (res_stall),
        .o_status        (res_status),
        .o_removed_value (res_removed_value),
        .o_length_after  (res_length_after)
    );

    list_checker #(
        .DEPTH(DEPTH)
    ) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (req_valid),
        .i_req_stall     (req_stall),
        .i_operation     (req_operation),
        .i_value         (req_value),
        .i_position      (req_position),
        .i_res_valid     (res_valid),
        .i_res_stall     (res_stall),
        .i_status        (res_status),
        .i_removed_value (res_removed_value),
        .i_length_after  (res_length_after),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_empty_hits    (empty_hits),
        .o_full_hits     (full_hits)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // hard stop
    initial begin
        #2_000_000;
        $display("bounded_positional_list verification failed");
        $finish;
    end

    // one request, with an optional random gap in front
    task automatic issue_request(input logic [OP_W-1:0] op,
                                 input logic [VAL_W-1:0] val,
                                 input logic [POS_W-1:0] pos);
        if ($urandom_range(99) < idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        req_valid     <= 1'b1;
        req_operation <= op;
        req_value     <= val;
        req_position  <= pos;
        @(posedge i_clk);
        while (req_stall) @(posedge i_clk);
        request_count++;
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        req_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // mostly random data, sometimes the extremes
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(15))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // positions mostly around the list length, sometimes anywhere
    function automatic logic [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (r < 70) return POS_W'($urandom_range(DEPTH + 3));
        if (r < 90) return POS_W'($urandom_range(127));
        return (r < 95) ? POS_W'(0) : POS_W'(127);
    endfunction

    function automatic logic [OP_W-1:0] pick_operation(input t_walk walk);
        int r;
        int ins_pct;
        r = $urandom_range(99);
        ins_pct = (walk == WALK_FILL) ? 70 : (walk == WALK_DRAIN) ? 30 : 50;
        if (r < 2) return ($urandom_range(1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
        if ($urandom_range(99) < ins_pct) begin
            case ($urandom_range(2))
                0: return OP_PUSH_TAIL;
                1: return OP_PUSH_HEAD;
                default: return OP_INSERT_AT;
            endcase
        end
        case ($urandom_range(2))
            0: return OP_POP_TAIL;
            1: return OP_POP_HEAD;
            default: return OP_DELETE_AT;
        endcase
    endfunction

    // stimulus and verdict
    initial begin
        int idle_mix[4];
        int stall_mix[4];
        t_walk walk;
        idle_mix  = '{0, 70, 0, 14};
        stall_mix = '{0, 0, 70, 14};
        request_count = 0;
        idle_pct      = 0;
        i_rst_n       <= 1'b0;
        req_valid     <= 1'b0;
        req_operation <= OP_PUSH_TAIL;
        req_value     <= '0;
        req_position  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // deletes from an empty list
        issue_request(OP_POP_TAIL, 32'h1234_5678, 7'd0);
        issue_request(OP_POP_HEAD, 32'h0, 7'd127);
        issue_request(OP_DELETE_AT, 32'hffff_ffff, 7'd5);
        // inserts at both ends, position zero and past the tail
        issue_request(OP_PUSH_TAIL, 32'h7fff_ffff, 7'd0);
        issue_request(OP_PUSH_HEAD, 32'h8000_0000, 7'd0);
        issue_request(OP_INSERT_AT, 32'h0000_0000, 7'd0);
        issue_request(OP_INSERT_AT, 32'hffff_ffff, 7'd127);
        issue_request(OP_INSERT_AT, 32'h5a5a_a5a5, 7'd2);
        // deletes at position zero, past the tail and inside
        issue_request(OP_DELETE_AT, 32'h0, 7'd0);
        issue_request(OP_DELETE_AT, 32'h0, 7'd127);
        issue_request(OP_DELETE_AT, 32'h0, 7'd2);
        // unused codes leave the list alone
        issue_request(OP_SPARE_6, 32'hffff_ffff, 7'd127);
        issue_request(OP_SPARE_7, 32'hffff_ffff, 7'd127);
        // fill up, then inserts into a full list
        for (int k = 0; k < DEPTH - 2; k++)
            issue_request(OP_PUSH_TAIL, VAL_W'(k + 1), 7'd0);
        issue_request(OP_PUSH_TAIL, 32'h1111_1111, 7'd0);
        issue_request(OP_PUSH_HEAD, 32'h2222_2222, 7'd0);
        issue_request(OP_INSERT_AT, 32'h3333_3333, 7'd3);

        // random walks under each idle/stall mix
        for (int ph = 0; ph < 4; ph++) begin
            drain_results();
            idle_pct  = idle_mix[ph];
            stall_pct <= stall_mix[ph];
            walk = WALK_MIXED;
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n % MODE_RUN == 0) walk = t_walk'($urandom_range(2));
                issue_request(pick_operation(walk), pick_value(), pick_position());
            end
        end

        // let the last results out
        req_valid <= 1'b0;
        stall_pct <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);

        $display("covered %0d requests over four idle/stall mixes", request_count);
        $display("checked %0d results, %0d on an empty list and %0d on a full list",
                 checked, empty_hits, full_hits);
        if (fail_count == 0 && pending == 0) begin
            $display("bounded_positional_list verification clean");
        end else begin
            $display("bounded_positional_list verification failed");
        end
        $finish;
    end

endmodule
